[src/mtsm_pkg.sv]
// Shared types, constants and the sine lookup for the multichannel tone synth mixer.
package mtsm_pkg;

   // Function codes of a request.
   localparam logic [1:0] FUNC_TICK     = 2'd0;
   localparam logic [1:0] FUNC_START    = 2'd1;
   localparam logic [1:0] FUNC_STOP     = 2'd2;
   localparam logic [1:0] FUNC_STOP_ALL = 2'd3;

   // Waveform codes as stored per channel.
   localparam logic [2:0] WF_SINE     = 3'd0;
   localparam logic [2:0] WF_SQUARE   = 3'd1;
   localparam logic [2:0] WF_SAW      = 3'd2;
   localparam logic [2:0] WF_TRIANGLE = 3'd3;
   localparam logic [2:0] WF_NOISE    = 3'd4;

   localparam logic [15:0] NOISE_SEED = 16'hace1;

   // Mix accumulator: 16 voices plus the external sample fit in 21 signed bits.
   localparam int MIX_W = 21;

   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      CMD_TICK,
      CMD_START,
      CMD_STOP,
      CMD_STOP_ALL
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [3:0]         chan;
      logic [31:0]        step;
      logic [2:0]         wave;
      logic [23:0]        duration;
      logic signed [15:0] extra;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } back_state_type;

   // First quadrant of the sine, scaled to 32767.
   localparam logic [15:0] QUARTER_SINE [0:64] = '{
      16'd0,     16'd804,   16'd1607,  16'd2410,  16'd3211,  16'd4011,  16'd4807,  16'd5601,
      16'd6392,  16'd7179,  16'd7961,  16'd8739,  16'd9511,  16'd10278, 16'd11038, 16'd11792,
      16'd12539, 16'd13278, 16'd14009, 16'd14732, 16'd15446, 16'd16150, 16'd16845, 16'd17530,
      16'd18204, 16'd18867, 16'd19519, 16'd20159, 16'd20787, 16'd21402, 16'd22004, 16'd22594,
      16'd23169, 16'd23731, 16'd24278, 16'd24811, 16'd25329, 16'd25831, 16'd26318, 16'd26789,
      16'd27244, 16'd27683, 16'd28105, 16'd28510, 16'd28897, 16'd29268, 16'd29621, 16'd29955,
      16'd30272, 16'd30571, 16'd30851, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31970,
      16'd32137, 16'd32284, 16'd32412, 16'd32520, 16'd32609, 16'd32678, 16'd32727, 16'd32757,
      16'd32767
   };

   // Full 256-entry sine table built from the quarter wave by mirroring.
   function automatic logic signed [15:0] sine_lookup(input logic [7:0] idx);
      logic [6:0]  q;
      logic [6:0]  qi;
      logic [15:0] m;
      q  = idx[6:0];
      qi = (q <= 7'd64) ? q : 7'(8'd128 - {1'b0, q});
      m  = QUARTER_SINE[qi];
      return idx[7] ? $signed(16'(-m)) : $signed(m);
   endfunction

endpackage

[src/mtsm_front.sv]
// Request decoder: classifies requests into queue commands and drops out-of-range ones.
module mtsm_front
   import mtsm_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_channel,
   input  logic [31:0]        req_phase_step,
   input  logic [2:0]         req_waveform,
   input  logic [23:0]        req_duration_samples,
   input  logic signed [15:0] req_extra_sample,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic in_range;
   logic drop;

   assign in_range  = ({1'b0, req_channel} < 5'(NUM_CHANNELS));
   assign req_ready = ~q_full;

   always_comb begin
      q_cmd.chan     = req_channel;
      q_cmd.step     = req_phase_step;
      q_cmd.wave     = (req_waveform > WF_NOISE) ? WF_SQUARE : req_waveform;
      q_cmd.duration = req_duration_samples;
      q_cmd.extra    = req_extra_sample;
      q_cmd.kind     = CMD_TICK;
      drop           = 1'b0;
      unique case (req_func)
         FUNC_TICK: q_cmd.kind = CMD_TICK;
         FUNC_START: begin
            q_cmd.kind = CMD_START;
            drop       = ~in_range;
         end
         FUNC_STOP: begin
            q_cmd.kind = CMD_STOP;
            drop       = ~in_range;
         end
         FUNC_STOP_ALL: q_cmd.kind = CMD_STOP_ALL;
         default: q_cmd.kind = CMD_TICK;
      endcase
   end

   // A request aimed at a missing channel is taken and then discarded.
   assign q_push = req_valid & req_ready & ~drop;

endmodule

[src/mtsm_queue.sv]
// Short command queue between the request decoder and the channel engine.
module mtsm_queue
   import mtsm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   output logic    head_valid,
   output cmd_type head_cmd,
   input  logic    pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(p + 1'b1);
   endfunction

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = CNT_W'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = CNT_W'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

[src/mtsm_back.sv]
// Channel engine: applies start and stop commands and walks the channels on each tick unless paused.
module mtsm_back
   import mtsm_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               paused,
   input  logic               head_valid,
   input  cmd_type            head_cmd,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample
);

   localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam logic signed [MIX_W-1:0] SAT_MAX = MIX_W'(32767);
   localparam logic signed [MIX_W-1:0] SAT_MIN = -MIX_W'(32768);

   // Per-channel state; only the on bits need a reset.
   logic [31:0] phase_ff [NUM_CHANNELS];
   logic [31:0] step_ff  [NUM_CHANNELS];
   logic [23:0] left_ff  [NUM_CHANNELS];
   logic [2:0]  wave_ff  [NUM_CHANNELS];
   logic [15:0] noise_ff [NUM_CHANNELS];
   logic [NUM_CHANNELS-1:0] on_ff, on_in;

   back_state_type           state_ff, state_in;
   logic [CH_W-1:0]          cnt_ff, cnt_in;
   logic signed [MIX_W-1:0]  acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]       rsp_sample_ff, rsp_sample_in;

   logic [CH_W-1:0]    hidx;
   logic               start_we;
   logic               walk_we;
   logic [31:0]        p;
   logic [15:0]        r;
   logic               fb;
   logic [15:0]        noise_in;
   logic [31:0]        phase_in;
   logic [23:0]        left_in;
   logic signed [15:0] voice;
   logic signed [15:0] voice_gated;
   logic signed [15:0] sat;

   assign hidx = head_cmd.chan[CH_W-1:0];

   // Voice datapath for the channel under the walk counter.
   always_comb begin
      p        = phase_ff[cnt_ff];
      r        = noise_ff[cnt_ff];
      fb       = r[0] ^ r[1] ^ r[5] ^ r[6];
      noise_in = {fb, r[15:1]};
      phase_in = p + step_ff[cnt_ff];
      left_in  = (left_ff[cnt_ff] != '0) ? 24'(left_ff[cnt_ff] - 1'b1) : left_ff[cnt_ff];
      case (wave_ff[cnt_ff])
         WF_SINE:     voice = sine_lookup(p[31:24]);
         WF_SAW:      voice = $signed({~p[31], p[30:16]});
         WF_TRIANGLE: voice = p[31] ? $signed({p[30], ~p[29:15]})
                                    : $signed({~p[30], p[29:15]});
         WF_NOISE:    voice = $signed({~noise_in[15], noise_in[14:0]});
         default:     voice = p[31] ? 16'sd32767 : -16'sd32767;
      endcase
      voice_gated = on_ff[cnt_ff] ? voice : '0;
   end

   always_comb begin
      if (acc_ff > SAT_MAX) begin
         sat = 16'sh7fff;
      end else if (acc_ff < SAT_MIN) begin
         sat = 16'sh8000;
      end else begin
         sat = acc_ff[15:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      acc_in        = acc_ff;
      on_in         = on_ff;
      pop           = 1'b0;
      start_we      = 1'b0;
      walk_we       = 1'b0;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_sample_in = rsp_sample_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               unique case (head_cmd.kind)
                  CMD_START: begin
                     start_we    = 1'b1;
                     on_in[hidx] = 1'b1;
                     pop         = 1'b1;
                  end
                  CMD_STOP: begin
                     on_in[hidx] = 1'b0;
                     pop         = 1'b1;
                  end
                  CMD_STOP_ALL: begin
                     on_in = '0;
                     pop   = 1'b1;
                  end
                  CMD_TICK: begin
                     if (paused) begin
                        acc_in   = '0;
                        state_in = ST_DONE;
                     end else begin
                        acc_in   = MIX_W'(head_cmd.extra);
                        cnt_in   = '0;
                        state_in = ST_WALK;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_WALK: begin
            walk_we = 1'b1;
            acc_in  = acc_ff + MIX_W'(voice_gated);
            if (on_ff[cnt_ff] && left_ff[cnt_ff] == 24'd1) begin
               on_in[cnt_ff] = 1'b0;
            end
            if (cnt_ff == CH_W'(NUM_CHANNELS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = CH_W'(cnt_ff + 1'b1);
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sample_in = sat;
               pop           = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         on_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         on_ff        <= on_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      rsp_sample_ff <= rsp_sample_in;
   end

   always_ff @(posedge clock) begin
      if (start_we) begin
         phase_ff[hidx] <= '0;
         step_ff[hidx]  <= head_cmd.step;
         wave_ff[hidx]  <= head_cmd.wave;
         left_ff[hidx]  <= head_cmd.duration;
         noise_ff[hidx] <= NOISE_SEED;
      end else if (walk_we && on_ff[cnt_ff]) begin
         phase_ff[cnt_ff] <= phase_in;
         left_ff[cnt_ff]  <= left_in;
         if (wave_ff[cnt_ff] == WF_NOISE) begin
            noise_ff[cnt_ff] <= noise_in;
         end
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;

endmodule

[src/multichannel_tone_synth_mixer.sv]
// Top level of the multichannel tone synth mixer: decoder, command queue and channel engine.
//
// A phase-accumulator tone generator with NUM_CHANNELS voices and a saturating mixer.
// A request is one of four commands: tick, start tone, stop channel or stop all channels.
// Only a tick returns a response, the mixed 16-bit sample; start and stop return nothing,
// and start or stop aimed at a channel number not below NUM_CHANNELS is accepted and ignored.
// Requests pass through a two-entry command queue, so the input side keeps accepting while
// the engine works or while a finished sample waits in the output register, until the
// queue is full. The engine applies each start or stop command from its idle state. A tick
// is issued from the idle state, then walks the channels in turn, reading, advancing and
// accumulating each voice through the single shared voice datapath, and finally saturates
// the sum and loads the output register, waiting while the consumer still holds it.
// While paused, a tick skips the walk, returns zero and advances no channel.
// The paused register is written through csr_write_enable / csr_write_data and resets to 0.
module multichannel_tone_synth_mixer
   import mtsm_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [3:0]         req_channel,
   input  logic [31:0]        req_phase_step,
   input  logic [2:0]         req_waveform,
   input  logic [23:0]        req_duration_samples,
   input  logic signed [15:0] req_extra_sample,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_write_enable,
   input  logic               csr_write_data
);

   logic    paused_ff, paused_in;
   logic    q_full;
   logic    q_push;
   cmd_type q_cmd;
   logic    head_valid;
   cmd_type head_cmd;
   logic    q_pop;

   // Pause control register.
   assign paused_in = csr_write_enable ? csr_write_data : paused_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         paused_ff <= 1'b0;
      end else begin
         paused_ff <= paused_in;
      end
   end

   // The decoder turns each request into a queue command.
   mtsm_front #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_func             (req_func),
      .req_channel          (req_channel),
      .req_phase_step       (req_phase_step),
      .req_waveform         (req_waveform),
      .req_duration_samples (req_duration_samples),
      .req_extra_sample     (req_extra_sample),
      .q_full               (q_full),
      .q_push               (q_push),
      .q_cmd                (q_cmd)
   );

   // The queue decouples request acceptance from channel processing.
   mtsm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (q_cmd),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop)
   );

   // The engine owns all channel state and the output register.
   mtsm_back #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .paused     (paused_ff),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_sample (rsp_sample)
   );

endmodule
